// ===== hdl/pmm_pkg.sv =====
package pmm_pkg;

  localparam int LIMB_W      = 32;
  localparam int ACC_W       = 127;
  localparam int KEY_W       = 64;
  localparam int BLK_BYTES   = 15;
  localparam int CNT_W       = 4;
  localparam int CNT_LSB     = 120;
  localparam int IN_TDATA_W  = 128;
  localparam int OUT_TDATA_W = 128;
  localparam int STEP_W      = 4;
  localparam int NUM_STEPS   = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int COL_W       = 68;

  localparam logic [KEY_W-1:0] CLAMP_LO = 64'h0FFF_FFFC_0FFF_FFFF;
  localparam logic [KEY_W-1:0] CLAMP_HI = 64'h07FF_FFFC_0FFF_FFFC;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_R_LOW  = 2'd0,
    CFG_R_HIGH = 2'd1,
    CFG_S_LOW  = 2'd2,
    CFG_S_HIGH = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic              load;
    logic              mul_en;
    logic [STEP_W-1:0] step;
    logic              red1;
    logic              red2;
    logic              tag_ld;
  } pmm_cmd_t;

  typedef struct packed {
    logic cnt_zero;
  } pmm_stat_t;

  typedef struct packed {
    logic [1:0] ai;
    logic [1:0] bj;
    logic       col_end;
  } step_info_t;

  // limb products ordered column by column (ai + bj rising)
  function automatic step_info_t step_info(input logic [STEP_W-1:0] step);
    step_info_t s;
    unique case (step)
      4'd0:    s = '{ai: 2'd0, bj: 2'd0, col_end: 1'b1};
      4'd1:    s = '{ai: 2'd0, bj: 2'd1, col_end: 1'b0};
      4'd2:    s = '{ai: 2'd1, bj: 2'd0, col_end: 1'b1};
      4'd3:    s = '{ai: 2'd0, bj: 2'd2, col_end: 1'b0};
      4'd4:    s = '{ai: 2'd1, bj: 2'd1, col_end: 1'b0};
      4'd5:    s = '{ai: 2'd2, bj: 2'd0, col_end: 1'b1};
      4'd6:    s = '{ai: 2'd0, bj: 2'd3, col_end: 1'b0};
      4'd7:    s = '{ai: 2'd1, bj: 2'd2, col_end: 1'b0};
      4'd8:    s = '{ai: 2'd2, bj: 2'd1, col_end: 1'b0};
      4'd9:    s = '{ai: 2'd3, bj: 2'd0, col_end: 1'b1};
      4'd10:   s = '{ai: 2'd1, bj: 2'd3, col_end: 1'b0};
      4'd11:   s = '{ai: 2'd2, bj: 2'd2, col_end: 1'b0};
      4'd12:   s = '{ai: 2'd3, bj: 2'd1, col_end: 1'b1};
      4'd13:   s = '{ai: 2'd2, bj: 2'd3, col_end: 1'b0};
      4'd14:   s = '{ai: 2'd3, bj: 2'd2, col_end: 1'b1};
      4'd15:   s = '{ai: 2'd3, bj: 2'd3, col_end: 1'b1};
      default: s = '{ai: 2'd0, bj: 2'd0, col_end: 1'b0};
    endcase
    return s;
  endfunction

endpackage

// ===== hdl/pmm_dp.sv =====
module pmm_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  pmm_pkg::cfg_idx_t                cfg_addr,
  input  logic [pmm_pkg::KEY_W-1:0]        cfg_wdata,
  input  logic [pmm_pkg::IN_TDATA_W-1:0]   in_data,
  input  pmm_pkg::pmm_cmd_t                cmd,
  output pmm_pkg::pmm_stat_t               stat,
  output logic [pmm_pkg::OUT_TDATA_W-1:0]  out_data
);
  import pmm_pkg::*;

  logic [KEY_W-1:0]        key_r_low_r, key_r_high_r, key_s_low_r, key_s_high_r;
  logic [ACC_W-1:0]        acc_r;
  logic [2*KEY_W-1:0]      a_r;
  logic [2*LIMB_W-1:0]     prod_r;
  logic                    pv_r;
  logic                    end_r;
  logic [COL_W-1:0]        col_r;
  logic [2:0]              wk_r;
  logic [7:0][LIMB_W-1:0]  w_r;
  logic [2*KEY_W-1:0]      s_r;
  logic [OUT_TDATA_W-1:0]  out_r;

  logic [CNT_W-1:0]        cnt;
  logic [8*BLK_BYTES:0]    padded;
  logic [2*KEY_W-1:0]      sum_blk;
  logic [2*KEY_W-1:0]      r_full;
  step_info_t              info;
  logic [LIMB_W-1:0]       a_limb, b_limb;
  logic [2*LIMB_W-1:0]     prod_nxt;
  logic [COL_W-1:0]        colsum;
  logic [8*LIMB_W-1:0]     prod_all;
  logic [2*KEY_W-1:0]      red_t, red_u;

  assign cnt = in_data[CNT_LSB +: CNT_W];

  always_comb begin
    for (int b = 0; b < BLK_BYTES; b++) begin
      if (CNT_W'(b) < cnt) begin
        padded[8*b +: 8] = in_data[8*b +: 8];
      end else if (CNT_W'(b) == cnt) begin
        padded[8*b +: 8] = 8'h01;
      end else begin
        padded[8*b +: 8] = 8'h00;
      end
    end
    padded[8*BLK_BYTES] = (cnt == CNT_W'(BLK_BYTES));
  end

  assign sum_blk  = {1'b0, acc_r} + {7'b0, padded};
  assign r_full   = {key_r_high_r & CLAMP_HI, key_r_low_r & CLAMP_LO};
  assign info     = step_info(cmd.step);
  assign a_limb   = a_r[{info.ai, 5'b0} +: LIMB_W];
  assign b_limb   = r_full[{info.bj, 5'b0} +: LIMB_W];
  assign prod_nxt = a_limb * b_limb;
  assign colsum   = col_r + {4'b0, prod_r};
  assign prod_all = w_r;
  assign red_t    = {1'b0, s_r[ACC_W-1:0]} + {127'b0, s_r[ACC_W]};
  assign red_u    = {1'b0, s_r[ACC_W-1:0]} + {127'b0, s_r[ACC_W]} + 128'd1;

  assign stat.cnt_zero = (cnt == '0);
  assign out_data      = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r_low_r  <= '0;
      key_r_high_r <= '0;
      key_s_low_r  <= '0;
      key_s_high_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_R_LOW:  key_r_low_r  <= cfg_wdata;
        CFG_R_HIGH: key_r_high_r <= cfg_wdata;
        CFG_S_LOW:  key_s_low_r  <= cfg_wdata;
        CFG_S_HIGH: key_s_high_r <= cfg_wdata;
        default:    key_r_low_r  <= key_r_low_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      pv_r  <= 1'b0;
      end_r <= 1'b0;
      col_r <= '0;
      wk_r  <= '0;
    end else begin
      pv_r  <= cmd.mul_en;
      end_r <= info.col_end;
      if (cmd.load) begin
        col_r <= '0;
        wk_r  <= '0;
      end else if (pv_r) begin
        if (end_r) begin
          col_r <= {32'b0, colsum[COL_W-1:LIMB_W]};
          wk_r  <= wk_r + 3'd1;
        end else begin
          col_r <= colsum;
        end
      end
      if (cmd.red2) begin
        acc_r <= red_u[ACC_W] ? red_u[ACC_W-1:0] : red_t[ACC_W-1:0];
      end else if (cmd.tag_ld) begin
        acc_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r <= sum_blk;
    end
    prod_r <= prod_nxt;
    if (pv_r && end_r) begin
      w_r[wk_r] <= colsum[LIMB_W-1:0];
      if (wk_r == 3'd6) begin
        w_r[7] <= colsum[2*LIMB_W-1:LIMB_W];
      end
    end
    if (cmd.red1) begin
      s_r <= {1'b0, prod_all[ACC_W-1:0]} + prod_all[2*ACC_W:ACC_W];
    end
    if (cmd.tag_ld) begin
      out_r <= {1'b0, acc_r} + {key_s_high_r, key_s_low_r};
    end
  end

endmodule

// ===== hdl/pmm_ctrl.sv =====
module pmm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic               in_tlast,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  pmm_pkg::pmm_stat_t stat,
  output pmm_pkg::pmm_cmd_t  cmd
);
  import pmm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DRAIN,
    S_RED1,
    S_RED2,
    S_TAG
  } state_t;

  state_t              state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                last_r, last_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                accept;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign accept     = in_tvalid && in_tready;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    cmd.step      = step_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          last_nxt = in_tlast;
          step_nxt = '0;
          if (stat.cnt_zero) begin
            state_nxt = in_tlast ? S_TAG : S_IDLE;
          end else begin
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        step_nxt   = step_r + 4'd1;
        if (step_r == STEP_W'(NUM_STEPS - 1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_RED1;
      end
      S_RED1: begin
        cmd.red1  = 1'b1;
        state_nxt = S_RED2;
      end
      S_RED2: begin
        cmd.red2  = 1'b1;
        state_nxt = last_r ? S_TAG : S_IDLE;
      end
      S_TAG: begin
        if (!out_valid_r || out_tready) begin
          cmd.tag_ld    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hdl/poly_mac_mod_2p127_minus_1.sv =====
// One-time polynomial MAC modulo 2^127-1 over blocks of up to 15 bytes. Load
// r and s through the cfg port while idle (r is clamped internally). Each
// request carries one block; bytes beyond byte_count are ignored and a 0x01
// byte follows the data. A block with a nonzero count forms its limb products
// on one shared 32x32 multiplier (one limb product per cycle), then passes
// S_DRAIN, S_RED1 and S_RED2 before the next ready. A zero-count block adds
// nothing; a non-final one leaves the input ready in the next cycle. The last
// block then forms the tag (acc + s mod 2^128) into the output register,
// which holds it until taken while new blocks are accepted.
module poly_mac_mod_2p127_minus_1 (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // block_low[63:0], block_high[119:64], byte_count[123:120], zero fill
  input  logic [pmm_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // tag_low[63:0], tag_high[127:64]
  output logic [pmm_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                              cfg_wr_en,
  input  logic [pmm_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [pmm_pkg::KEY_W-1:0]         cfg_wdata
);
  import pmm_pkg::*;

  pmm_cmd_t  cmd;
  pmm_stat_t stat;

  pmm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  pmm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_idx_t'(cfg_addr)),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_tdata)
  );

`ifndef SYNTHESIS
  // a block with data occupies the multiplier: not ready next cycle
  a_busy_after_data: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tdata[CNT_LSB +: CNT_W] != '0)) |=> !in_tready)
    else $error("ready while multiplying");

  // an empty non-final block leaves the input ready in the next cycle
  a_empty_block_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tdata[CNT_LSB +: CNT_W] == '0) && !in_tlast)
    |=> in_tready)
    else $error("empty block stalled input");

  // a new tag appears only after the input side went busy
  a_tag_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("tag without processing");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");
`endif

endmodule

// ===== tb/poly_mac_mod_2p127_minus_1_tb.sv =====
`timescale 1ns / 1ps

module poly_mac_mod_2p127_minus_1_tb;
  import pmm_pkg::*;

  localparam int NUM_PHASES      = 8;
  localparam int RANDOM_BLOCKS   = 1930;
  localparam int RESET_KEY_ROWS  = 2;
  localparam int SETTLE_CYCLES   = 40;
  localparam logic [63:0]  ONES64  = {64{1'b1}};
  localparam logic [55:0]  ONES56  = {56{1'b1}};
  localparam logic [127:0] ONES128 = {128{1'b1}};
  localparam logic [127:0] P_MOD   = {1'b0, {127{1'b1}}};
  localparam logic [63:0]  R_MASK_LO = 64'h0FFF_FFFC_0FFF_FFFF;
  localparam logic [63:0]  R_MASK_HI = 64'h07FF_FFFC_0FFF_FFFC;

  typedef struct {
    logic [63:0]  lo;
    logic [55:0]  hi;
    logic [3:0]   cnt;
    logic         is_last;
    logic         typed;
    logic [127:0] tag;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en;
  logic [CFG_IDX_W-1:0]   cfg_addr;
  logic [KEY_W-1:0]       cfg_wdata;

  logic [126:0] acc;
  logic [63:0]  key_r_lo, key_r_hi, key_s_lo, key_s_hi;
  logic [127:0] pending_tags[$];
  dir_row_t     dir_rows[$];
  int           errors = 0;
  int           in_idle_pct = 0;
  int           out_stall_pct = 0;

  poly_mac_mod_2p127_minus_1 dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [126:0] mul_mod_p(input logic [127:0] a, input logic [123:0] b);
    logic [251:0] prod;
    logic [127:0] x;
    prod = {124'b0, a} * {128'b0, b};
    x = {1'b0, prod[126:0]} + {3'b0, prod[251:127]};
    x = {1'b0, x[126:0]} + {127'b0, x[127]};
    x = {1'b0, x[126:0]} + {127'b0, x[127]};
    if (x == P_MOD) x = '0;
    return x[126:0];
  endfunction

  // absorb one block into the accumulator; returns 1 when a tag is due
  function automatic bit absorb_block(input logic [63:0] lo, input logic [55:0] hi,
                                      input logic [3:0] cnt, input logic is_last,
                                      output logic [127:0] tag);
    logic [127:0] blk;
    logic [127:0] r;
    int nb;
    tag = '0;
    if (cnt != 0) begin
      nb  = 8 * cnt;
      blk = ({8'b0, hi, lo} & ((128'd1 << nb) - 128'd1)) | (128'd1 << nb);
      r   = {key_r_hi & R_MASK_HI, key_r_lo & R_MASK_LO};
      acc = mul_mod_p({1'b0, acc} + blk, r[123:0]);
    end
    if (!is_last) return 1'b0;
    tag = {1'b0, acc} + {key_s_hi, key_s_lo};
    acc = '0;
    return 1'b1;
  endfunction

  task automatic send_block(input logic [63:0] lo, input logic [55:0] hi,
                            input logic [3:0] cnt, input logic is_last,
                            input logic typed, input logic [127:0] typed_tag);
    logic [127:0] tag;
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0000, cnt, hi, lo};
    in_tlast  <= is_last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (absorb_block(lo, hi, cnt, is_last, tag))
      pending_tags.push_back(typed ? typed_tag : tag);
  endtask

  // stop sending, wait for every tag, then let in-flight blocks finish
  task automatic drain(input int tail);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_tags.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_keys(input logic [63:0] r_lo, input logic [63:0] r_hi,
                            input logic [63:0] s_lo, input logic [63:0] s_hi);
    key_r_lo = r_lo;
    key_r_hi = r_hi;
    key_s_lo = s_lo;
    key_s_hi = s_hi;
    cfg_wr_en <= 1'b1;
    cfg_addr  <= CFG_R_LOW;
    cfg_wdata <= r_lo;
    @(posedge clk);
    cfg_addr  <= CFG_R_HIGH;
    cfg_wdata <= r_hi;
    @(posedge clk);
    cfg_addr  <= CFG_S_LOW;
    cfg_wdata <= s_lo;
    @(posedge clk);
    cfg_addr  <= CFG_S_HIGH;
    cfg_wdata <= s_hi;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  always @(posedge clk) begin : tag_check
    logic [127:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_tags.size() == 0) begin
        $error("unexpected tag %h", out_tdata);
        errors++;
      end else begin
        want = pending_tags.pop_front();
        if (out_tdata[63:0] !== want[63:0]) begin
          $error("tag_low: expected %h, got %h", want[63:0], out_tdata[63:0]);
          errors++;
        end
        if (out_tdata[127:64] !== want[127:64]) begin
          $error("tag_high: expected %h, got %h", want[127:64], out_tdata[127:64]);
          errors++;
        end
      end
    end
    out_tready <= ($urandom_range(99) >= out_stall_pct);
  end

  initial begin
    #(20_000_000);
    $display("tb: failure");
    $finish;
  end

  initial begin
    int quota, n, k, nblk, mode, i;
    bit noise, paused, is_last;
    logic [3:0] cnt;
    logic [63:0] lo, tmp;
    logic [63:0] rk_lo, rk_hi, sk_lo, sk_hi;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_addr  = CFG_R_LOW;
    cfg_wdata = '0;
    acc       = '0;
    key_r_lo  = '0;
    key_r_hi  = '0;
    key_s_lo  = '0;
    key_s_hi  = '0;

    // keys at reset: r = 0 and s = 0, so every tag is 0
    dir_rows.push_back('{64'h0, 56'h0, 4'd0, 1'b1, 1'b1, 128'h0});
    dir_rows.push_back('{ONES64, ONES56, 4'd15, 1'b1, 1'b1, 128'h0});
    // r and s all ones
    dir_rows.push_back('{64'h0, 56'h0, 4'd0, 1'b1, 1'b1, ONES128});
    dir_rows.push_back('{ONES64, ONES56, 4'd15, 1'b0, 1'b0, 128'h0});
    dir_rows.push_back('{64'h0, 56'h0, 4'd15, 1'b0, 1'b0, 128'h0});
    dir_rows.push_back('{ONES64, ONES56, 4'd7, 1'b0, 1'b0, 128'h0});
    dir_rows.push_back('{ONES64, ONES56, 4'd8, 1'b0, 1'b0, 128'h0});
    dir_rows.push_back('{ONES64, ONES56, 4'd1, 1'b0, 1'b0, 128'h0});
    dir_rows.push_back('{ONES64, ONES56, 4'd14, 1'b1, 1'b0, 128'h0});
    dir_rows.push_back('{ONES64, ONES56, 4'd0, 1'b0, 1'b0, 128'h0});
    dir_rows.push_back('{64'h0, 56'h0, 4'd0, 1'b1, 1'b1, ONES128});
    dir_rows.push_back('{64'h0123456789ABCDEF, 56'hFEDCBA98765432, 4'd15, 1'b0, 1'b0, 128'h0});
    dir_rows.push_back('{64'hA5A5A5A5A5A5A5A5, 56'h5A5A5A5A5A5A5A, 4'd3, 1'b0, 1'b0, 128'h0});
    dir_rows.push_back('{64'h8000000000000001, 56'h80000000000001, 4'd15, 1'b1, 1'b0, 128'h0});
    dir_rows.push_back('{64'h0, 56'h0, 4'd1, 1'b1, 1'b0, 128'h0});
    dir_rows.push_back('{ONES64, ONES56, 4'd2, 1'b0, 1'b0, 128'h0});
    dir_rows.push_back('{ONES64, ONES56, 4'd4, 1'b0, 1'b0, 128'h0});
    dir_rows.push_back('{ONES64, ONES56, 4'd5, 1'b0, 1'b0, 128'h0});
    dir_rows.push_back('{ONES64, ONES56, 4'd6, 1'b0, 1'b0, 128'h0});
    dir_rows.push_back('{ONES64, ONES56, 4'd9, 1'b0, 1'b0, 128'h0});
    dir_rows.push_back('{ONES64, ONES56, 4'd10, 1'b0, 1'b0, 128'h0});
    dir_rows.push_back('{ONES64, ONES56, 4'd11, 1'b0, 1'b0, 128'h0});
    dir_rows.push_back('{ONES64, ONES56, 4'd12, 1'b0, 1'b0, 128'h0});
    dir_rows.push_back('{ONES64, ONES56, 4'd13, 1'b1, 1'b0, 128'h0});

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < dir_rows.size(); i++) begin
      if (i == RESET_KEY_ROWS) begin
        drain(SETTLE_CYCLES);
        write_keys(ONES64, ONES64, ONES64, ONES64);
      end
      send_block(dir_rows[i].lo, dir_rows[i].hi, dir_rows[i].cnt, dir_rows[i].is_last,
                 dir_rows[i].typed, dir_rows[i].tag);
    end

    quota = RANDOM_BLOCKS / NUM_PHASES;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain(SETTLE_CYCLES);
      mode = ph % 4;
      in_idle_pct   = (mode == 1) ? 60 : (mode == 3) ? 37 : 0;
      out_stall_pct = (mode == 2) ? 60 : (mode == 3) ? 37 : 0;
      rk_lo = {$urandom(), $urandom()};
      rk_hi = {$urandom(), $urandom()};
      sk_lo = {$urandom(), $urandom()};
      sk_hi = {$urandom(), $urandom()};
      case (ph)
        0: begin
          rk_lo = ONES64; rk_hi = ONES64; sk_lo = ONES64; sk_hi = ONES64;
        end
        1: begin
          sk_lo = '0; sk_hi = '0;
        end
        2: begin
          rk_lo = '0; rk_hi = '0;
        end
        default: ;
      endcase
      write_keys(rk_lo, rk_hi, sk_lo, sk_hi);

      n = 0;
      paused = 1'b0;
      while (n < quota) begin
        // mostly full blocks closed by a last one of random count; some messages random throughout
        noise = ($urandom_range(99) < 15);
        nblk  = $urandom_range(1, 8);
        for (k = 0; k < nblk; k++) begin
          is_last = (k == nblk - 1);
          if (noise || is_last) cnt = 4'($urandom_range(0, 15));
          else cnt = 4'd15;
          lo  = {$urandom(), $urandom()};
          tmp = {$urandom(), $urandom()};
          send_block(lo, tmp[55:0], cnt, is_last, 1'b0, 128'h0);
        end
        n += nblk;
        if (!paused && n >= quota / 2) begin
          drain(0);
          paused = 1'b1;
        end
      end
    end

    drain(SETTLE_CYCLES);
    if (pending_tags.size() != 0) begin
      $error("%0d tags never arrived", pending_tags.size());
      errors++;
    end
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
